@@ rtl/ecal_pkg.sv @@
// ----------------------------------------------------------------------------
// ecal_pkg: shared types and constants of the epoch-seconds to calendar block
// Time constants, the front-to-back queue entry and the month length table.
// ----------------------------------------------------------------------------
package ecal_pkg;

    localparam logic [16:0] DAY_SEC    = 17'd86400;
    localparam logic [11:0] HOUR_SEC   = 12'd3600;
    localparam logic [5:0]  MIN_SEC    = 6'd60;
    localparam logic [2:0]  WEEK_DAYS  = 3'd7;

    // quotient = (x * MUL) >> SHIFT, exact over the range each x can take;
    // the day step works on the seconds shifted down first (86400 = 128 * 675)
    localparam int unsigned DAY_PRE    = 7;
    localparam logic [24:0] DAY_MUL    = 25'd25451659;
    localparam int unsigned DAY_SHIFT  = 34;
    localparam logic [17:0] HOUR_MUL   = 18'd149131;
    localparam int unsigned HOUR_SHIFT = 29;
    localparam logic [12:0] MIN_MUL    = 13'd4370;
    localparam int unsigned MIN_SHIFT  = 18;
    localparam logic [15:0] WDAY_MUL   = 16'd37450;
    localparam int unsigned WDAY_SHIFT = 18;

    localparam logic [14:0] EPOCH_WDAY = 15'd4;
    localparam logic [10:0] EPOCH_YEAR = 11'd1970;
    localparam logic [1:0]  EPOCH_M4   = 2'd2;
    localparam logic [6:0]  EPOCH_M100 = 7'd70;
    localparam logic [8:0]  EPOCH_M400 = 9'd370;

    localparam logic [8:0]  YEAR_DAYS  = 9'd365;
    localparam logic [8:0]  LEAP_DAYS  = 9'd366;
    localparam logic [3:0]  LAST_MON   = 4'd11;

    typedef struct packed {
        logic [14:0] days;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } t_front_item;

    // month index counts from 0 for January
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon) inside
            4'd1:                   len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/epoch_seconds_to_calendar.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970-01-01 UTC to calendar fields
// Gives year, month, day, hour, minute, second and weekday (0 = Sunday).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_epoch_seconds. A request is taken
//   at a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with one result per request, in order.
//   The front splits the seconds by reciprocal multiplications with
//   constants, one step a cycle, then pushes to the queue; o_stall stays
//   high from acceptance until the push, so a new request is taken only
//   after the last is in the queue. A two-entry queue feeds the back,
//   which walks whole years, then months, one per cycle; the back's walk
//   sets the sustained rate for dates far from 1970.
//   While i_stall is high the result holds in its output register; the back
//   finishes the next request and waits, the queue fills, then the front
//   stops accepting.
//   Reset (synchronous, active low) empties the queue and drops any request
//   in progress and any pending result.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [30:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic [2:0]  o_weekday
);

    ecal_pkg::t_front_item push_item, pop_item;
    logic push, pop, full, empty;

    ecal_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_epoch_seconds (i_epoch_seconds),
        .i_full          (full),
        .o_push          (push),
        .o_item          (push_item)
    );

    ecal_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (pop_item)
    );

    ecal_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_item         (pop_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second       (o_second),
        .o_weekday      (o_weekday)
    );

endmodule

@@ rtl/ecal_front.sv @@
// ----------------------------------------------------------------------------
// ecal_front: request intake and time-of-day split
// Reciprocal multiplications by constants give days, hour, minute, second and
// weekday, one step a cycle.
// ----------------------------------------------------------------------------
module ecal_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [30:0]           i_epoch_seconds,
    input  logic                  i_full,
    output logic                  o_push,
    output ecal_pkg::t_front_item o_item
);

    typedef enum logic [7:0] {
        F_IDLE = 8'b00000001,
        F_DAY  = 8'b00000010,
        F_TOD  = 8'b00000100,
        F_HOUR = 8'b00001000,
        F_MREM = 8'b00010000,
        F_MIN  = 8'b00100000,
        F_SEC  = 8'b01000000,
        F_PUSH = 8'b10000000
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [30:0] r_secs, n_secs;
    logic [14:0] r_days, n_days;
    logic [16:0] r_tod, n_tod;
    logic [14:0] r_wx, n_wx;
    logic [11:0] r_wq, n_wq;
    logic [11:0] r_mrem, n_mrem;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [5:0]  r_second, n_second;
    logic [2:0]  r_wday, n_wday;

    logic [23:0] secs_hi;
    logic [48:0] day_prod;
    logic [31:0] day_base;
    logic [30:0] tod_full;
    logic [34:0] hour_prod;
    logic [30:0] wday_prod;
    logic [16:0] hour_base;
    logic [16:0] mrem_full;
    logic [14:0] wday_base;
    logic [14:0] wday_full;
    logic [24:0] min_prod;
    logic [11:0] sec_base;
    logic [11:0] sec_full;

    assign secs_hi   = 24'(r_secs >> ecal_pkg::DAY_PRE);
    assign day_prod  = secs_hi * ecal_pkg::DAY_MUL;
    assign day_base  = r_days * ecal_pkg::DAY_SEC;
    assign tod_full  = r_secs - day_base[30:0];
    assign hour_prod = r_tod * ecal_pkg::HOUR_MUL;
    assign wday_prod = r_wx * ecal_pkg::WDAY_MUL;
    assign hour_base = r_hour * ecal_pkg::HOUR_SEC;
    assign mrem_full = r_tod - hour_base;
    assign wday_base = r_wq * ecal_pkg::WEEK_DAYS;
    assign wday_full = r_wx - wday_base;
    assign min_prod  = r_mrem * ecal_pkg::MIN_MUL;
    assign sec_base  = r_minute * ecal_pkg::MIN_SEC;
    assign sec_full  = r_mrem - sec_base;

    always_comb begin
        n_state  = r_state;
        n_secs   = r_secs;
        n_days   = r_days;
        n_tod    = r_tod;
        n_wx     = r_wx;
        n_wq     = r_wq;
        n_mrem   = r_mrem;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_wday   = r_wday;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_secs  = i_epoch_seconds;
                    n_state = F_DAY;
                end
            end
            F_DAY: begin
                n_days  = 15'(day_prod >> ecal_pkg::DAY_SHIFT);
                n_state = F_TOD;
            end
            F_TOD: begin
                n_tod   = tod_full[16:0];
                // weekday: (days + 4) mod 7
                n_wx    = r_days + ecal_pkg::EPOCH_WDAY;
                n_state = F_HOUR;
            end
            F_HOUR: begin
                n_hour  = 5'(hour_prod >> ecal_pkg::HOUR_SHIFT);
                n_wq    = 12'(wday_prod >> ecal_pkg::WDAY_SHIFT);
                n_state = F_MREM;
            end
            F_MREM: begin
                n_mrem  = mrem_full[11:0];
                n_wday  = wday_full[2:0];
                n_state = F_MIN;
            end
            F_MIN: begin
                n_minute = 6'(min_prod >> ecal_pkg::MIN_SHIFT);
                n_state  = F_SEC;
            end
            F_SEC: begin
                n_second = sec_full[5:0];
                n_state  = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_secs   <= n_secs;
        r_days   <= n_days;
        r_tod    <= n_tod;
        r_wx     <= n_wx;
        r_wq     <= n_wq;
        r_mrem   <= n_mrem;
        r_hour   <= n_hour;
        r_minute <= n_minute;
        r_second <= n_second;
        r_wday   <= n_wday;
    end

    assign o_stall        = (r_state != F_IDLE);
    assign o_push         = (r_state == F_PUSH) && !i_full;
    assign o_item.days    = r_days;
    assign o_item.hour    = r_hour;
    assign o_item.minute  = r_minute;
    assign o_item.second  = r_second;
    assign o_item.weekday = r_wday;

endmodule

@@ rtl/ecal_fifo.sv @@
// ----------------------------------------------------------------------------
// ecal_fifo: two-entry queue between front and back
// Register-based; push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module ecal_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ecal_pkg::t_front_item i_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_empty,
    output ecal_pkg::t_front_item o_data
);

    ecal_pkg::t_front_item r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd];

endmodule

@@ rtl/ecal_back.sv @@
// ----------------------------------------------------------------------------
// ecal_back: year and month walk, result register
// Takes whole years, then whole months, off the day count; holds the result.
// ----------------------------------------------------------------------------
module ecal_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  ecal_pkg::t_front_item i_item,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [10:0]           o_year,
    output logic [3:0]            o_month,
    output logic [4:0]            o_day_of_month,
    output logic [4:0]            o_hour,
    output logic [5:0]            o_minute,
    output logic [5:0]            o_second,
    output logic [2:0]            o_weekday
);

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_YEAR  = 4'b0010,
        B_MONTH = 4'b0100,
        B_HOLD  = 4'b1000
    } t_bstate;

    t_bstate               r_state, n_state;
    ecal_pkg::t_front_item r_item, n_item;
    logic [14:0]           r_left, n_left;
    logic [10:0]           r_year, n_year;
    logic [1:0]            r_m4, n_m4;
    logic [6:0]            r_m100, n_m100;
    logic [8:0]            r_m400, n_m400;
    logic [3:0]            r_mon, n_mon;
    logic                  r_ovalid, n_ovalid;

    logic [10:0] r_oyear;
    logic [3:0]  r_omonth;
    logic [4:0]  r_oday;
    logic [4:0]  r_ohour;
    logic [5:0]  r_ominute, r_osecond;
    logic [2:0]  r_owday;

    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        load_out;

    assign leap = (r_m4 == 2'd0) && ((r_m100 != 7'd0) || (r_m400 == 9'd0));
    assign ylen = leap ? ecal_pkg::LEAP_DAYS : ecal_pkg::YEAR_DAYS;
    assign mlen = ecal_pkg::month_len(r_mon, leap);
    assign load_out = (r_state == B_HOLD) && (!r_ovalid || !i_stall);
    assign o_pop = (r_state == B_IDLE) && !i_empty;

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_left   = r_left;
        n_year   = r_year;
        n_m4     = r_m4;
        n_m100   = r_m100;
        n_m400   = r_m400;
        n_mon    = r_mon;
        n_ovalid = r_ovalid;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_item  = i_item;
                    n_left  = i_item.days;
                    n_year  = ecal_pkg::EPOCH_YEAR;
                    n_m4    = ecal_pkg::EPOCH_M4;
                    n_m100  = ecal_pkg::EPOCH_M100;
                    n_m400  = ecal_pkg::EPOCH_M400;
                    n_state = B_YEAR;
                end
            end
            B_YEAR: begin
                if (r_left >= {6'd0, ylen}) begin
                    n_left = r_left - {6'd0, ylen};
                    n_year = r_year + 11'd1;
                    n_m4   = r_m4 + 2'd1;
                    n_m100 = (r_m100 == 7'd99) ? 7'd0 : r_m100 + 7'd1;
                    n_m400 = (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
                end else begin
                    n_mon   = 4'd0;
                    n_state = B_MONTH;
                end
            end
            B_MONTH: begin
                if ((r_mon < ecal_pkg::LAST_MON) && (r_left >= {10'd0, mlen})) begin
                    n_left = r_left - {10'd0, mlen};
                    n_mon  = r_mon + 4'd1;
                end else begin
                    n_state = B_HOLD;
                end
            end
            B_HOLD: begin
                // wait for the result register to free up
                if (load_out) begin
                    n_ovalid = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_item <= n_item;
        r_left <= n_left;
        r_year <= n_year;
        r_m4   <= n_m4;
        r_m100 <= n_m100;
        r_m400 <= n_m400;
        r_mon  <= n_mon;
        if (load_out) begin
            r_oyear   <= r_year;
            r_omonth  <= r_mon + 4'd1;
            r_oday    <= r_left[4:0] + 5'd1;
            r_ohour   <= r_item.hour;
            r_ominute <= r_item.minute;
            r_osecond <= r_item.second;
            r_owday   <= r_item.weekday;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_year         = r_oyear;
    assign o_month        = r_omonth;
    assign o_day_of_month = r_oday;
    assign o_hour         = r_ohour;
    assign o_minute       = r_ominute;
    assign o_second       = r_osecond;
    assign o_weekday      = r_owday;

    a_mod4_tracks_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_YEAR || r_state == B_MONTH) |-> (r_m4 == r_year[1:0]))
        else $error("year mod 4 counter out of step");
    a_month_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MONTH) |-> (r_mon <= ecal_pkg::LAST_MON && r_left < 15'd366))
        else $error("month walk out of range");
    a_day_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_HOLD) |-> (r_left < 15'd31))
        else $error("day of month left over too large");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_valid)
        else $error("result loaded without valid");

endmodule
